// ===== rtl/tdts_pkg.sv =====
// ----------------------------------------------------------------------------
// tdts_pkg: shared types and constants for the task due-time scheduler
// Sweep word layout, mode and request codes, field widths.
// ----------------------------------------------------------------------------
package tdts_pkg;

    localparam int TID_W   = 4;
    localparam int DELAY_W = 31;
    localparam int TICK_W  = 32;

    localparam logic [DELAY_W-1:0] NO_WAIT = 31'h7fffffff;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_ARMED  = 2'd1;
    localparam logic [1:0] MODE_FORCED = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_ADV  = 2'd1;
    localparam logic [1:0] REQ_DONE = 2'd2;

    // word that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic               valid;
        logic [1:0]         req;
        logic [TID_W-1:0]   id;
        logic [1:0]         mode;
        logic [DELAY_W-1:0] first;
        logic [TICK_W-1:0]  elapsed;
        logic [TICK_W-1:0]  nd;
        logic [DELAY_W-1:0] wait_min;
        logic               forced;
    } sweep_t;

endpackage

// ===== rtl/tdts_cell.sv =====
// ----------------------------------------------------------------------------
// tdts_cell: one task entry of the scheduler chain
// Holds delay, mode and pending mark of one task, applies the passing
// request word to it and folds the entry into the running summary.
// ----------------------------------------------------------------------------
module tdts_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tdts_pkg::sweep_t sw_in,
    output tdts_pkg::sweep_t sw_out,
    output logic            fired
);
    import tdts_pkg::*;

    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [1:0]         mode_reg, mode_next;
    logic               pend_reg, pend_next;
    logic               fired_reg, fired_next;
    sweep_t             sw_reg, sw_next;
    logic               hit;

    assign hit = (32'(sw_in.id) == 32'(IDX));

    always_comb
    begin
        delay_next = delay_reg;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        fired_next = fired_reg;
        sw_next    = sw_in;
        if (sw_in.valid)
        begin
            fired_next = 1'b0;
            case (sw_in.req)
                REQ_SET:
                begin
                    if (hit && sw_in.mode != MODE_RSVD)
                    begin
                        if (sw_in.mode == MODE_ARMED)
                            delay_next = sw_in.first;
                        mode_next = sw_in.mode;
                        pend_next = 1'b0;
                    end
                end
                REQ_ADV:
                begin
                    if (mode_reg != MODE_OFF && !pend_reg)
                    begin
                        if (mode_reg == MODE_FORCED || {1'b0, delay_reg} <= sw_in.elapsed)
                        begin
                            pend_next  = 1'b1;
                            fired_next = 1'b1;
                        end
                        else
                        begin
                            // delay > elapsed here, so elapsed fits in 31 bits
                            delay_next = delay_reg - sw_in.elapsed[DELAY_W-1:0];
                        end
                    end
                end
                REQ_DONE:
                begin
                    if (hit)
                    begin
                        if (!sw_in.nd[TICK_W-1])
                        begin
                            delay_next = sw_in.nd[DELAY_W-1:0];
                            mode_next  = MODE_ARMED;
                        end
                        else
                        begin
                            mode_next = MODE_OFF;
                        end
                        pend_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // summary over the updated entry
        if (mode_next != MODE_OFF && !pend_next && delay_next < sw_in.wait_min)
            sw_next.wait_min = delay_next;
        sw_next.forced = sw_in.forced | (mode_next == MODE_FORCED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            mode_reg  <= MODE_OFF;
            pend_reg  <= 1'b0;
            fired_reg <= 1'b0;
            sw_reg    <= '0;
        end
        else
        begin
            delay_reg <= delay_next;
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            fired_reg <= fired_next;
            sw_reg    <= sw_next;
        end
    end

    assign sw_out = sw_reg;
    assign fired  = fired_reg;

endmodule

// ===== rtl/task_due_time_scheduler.sv =====
// Flow: a request word is registered at the chain head and walks the
// TASKS-cell chain; results are emitted once it leaves the last cell.
// A new request is taken only once the status word of the previous one
// has been issued; the chain walk, the run words and output stalls set the rate.
// Reset (rst_n, async, active low): all tasks off, delays and pending marks
// cleared, last tick zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// task_due_time_scheduler: task table with due-time tracking
// Set, advance and completion requests sweep a chain of task cells; the
// run words and a closing status word are then streamed out.
// ----------------------------------------------------------------------------
module task_due_time_scheduler #(
    parameter int TASKS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // task_id[3:0], mode_request[5:4], first_delay[36:6], now_tick[68:37],
    // fast_forward[100:69], next_delay[132:101], zero fill
    input  logic [135:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // run_task_id[3:0], shortest_wait[34:4], any_forced[35], zero fill
    output logic [39:0]  m_axis_tdata,
    // result_kind
    output logic         m_axis_tuser,
    // last_result
    output logic         m_axis_tlast
);
    import tdts_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [TICK_W-1:0]  last_tick_reg, last_tick_next;
    sweep_t             head_reg, head_next;
    sweep_t             chain [TASKS];
    logic [TASKS-1:0]   fired;
    logic [TASKS-1:0]   mask_reg, mask_next;
    logic [DELAY_W-1:0] wait_reg, wait_next;
    logic               forced_reg, forced_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg, m_kind_next;
    logic [TID_W-1:0]   m_id_reg, m_id_next;
    logic [DELAY_W-1:0] m_wait_reg, m_wait_next;
    logic               m_forced_reg, m_forced_next;
    logic               m_last_reg, m_last_next;

    logic               in_accept;
    logic               slot_free;

    function automatic logic [TID_W-1:0] lowest_set(input logic [TASKS-1:0] m);
        logic [TID_W-1:0] idx;
        idx = '0;
        for (int i = TASKS - 1; i >= 0; i--)
        begin
            if (m[i])
                idx = TID_W'(i);
        end
        return idx;
    endfunction

    genvar g;
    generate
        for (g = 0; g < TASKS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                tdts_cell #(.IDX(g)) u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .sw_in  (head_reg),
                    .sw_out (chain[g]),
                    .fired  (fired[g])
                );
            end
            else
            begin : g_rest
                tdts_cell #(.IDX(g)) u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .sw_in  (chain[g-1]),
                    .sw_out (chain[g]),
                    .fired  (fired[g])
                );
            end
        end
    endgenerate

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        last_tick_next = last_tick_reg;
        head_next      = head_reg;
        head_next.valid = 1'b0;
        mask_next      = mask_reg;
        wait_next      = wait_reg;
        forced_next    = forced_reg;
        m_valid_next   = m_valid_reg;
        m_kind_next    = m_kind_reg;
        m_id_next      = m_id_reg;
        m_wait_next    = m_wait_reg;
        m_forced_next  = m_forced_reg;
        m_last_next    = m_last_reg;

        if (m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    head_next.valid    = 1'b1;
                    head_next.req      = s_axis_tuser;
                    head_next.id       = s_axis_tdata[3:0];
                    head_next.mode     = s_axis_tdata[5:4];
                    head_next.first    = s_axis_tdata[36:6];
                    // wraps mod 2^32
                    head_next.elapsed  = s_axis_tdata[68:37] - last_tick_reg
                                         + s_axis_tdata[100:69];
                    head_next.nd       = s_axis_tdata[132:101];
                    head_next.wait_min = NO_WAIT;
                    head_next.forced   = 1'b0;
                    if (s_axis_tuser == REQ_ADV)
                        last_tick_next = s_axis_tdata[68:37];
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                // all fired flags are settled once the word leaves the last cell
                if (chain[TASKS-1].valid)
                begin
                    mask_next   = fired;
                    wait_next   = chain[TASKS-1].wait_min;
                    forced_next = chain[TASKS-1].forced;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    m_valid_next  = 1'b1;
                    m_wait_next   = wait_reg;
                    m_forced_next = forced_reg;
                    if (mask_reg != '0)
                    begin
                        m_kind_next = 1'b1;
                        m_id_next   = lowest_set(mask_reg);
                        m_last_next = 1'b0;
                        mask_next   = mask_reg & (mask_reg - TASKS'(1));
                    end
                    else
                    begin
                        m_kind_next = 1'b0;
                        m_id_next   = '0;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_tick_reg <= '0;
            head_reg      <= '0;
            mask_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_tick_reg <= last_tick_next;
            head_reg      <= head_next;
            mask_reg      <= mask_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wait_reg     <= wait_next;
        forced_reg   <= forced_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_wait_reg   <= m_wait_next;
        m_forced_reg <= m_forced_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_forced_reg, m_wait_reg, m_id_reg};
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== tb/tb_task_due_time_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_task_due_time_scheduler: self-checking bench for the task scheduler
// Drives set, advance and completion requests over the input stream and
// predicts each run and status word from a private copy of the task table.
// Output words are checked in order against the predicted words.
// ----------------------------------------------------------------------------
module tb_task_due_time_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    import tdts_pkg::*;

    localparam int TASKS = 16;
    localparam logic [1:0] REQ_RSVD = 2'd3;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_RUN    = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [TID_W-1:0]   id;
        logic [DELAY_W-1:0] min_wait;
        logic               forced;
        logic               last;
    } sched_word_t;

    // task table mirror and queue of words the block still owes us
    class sched_tracker;
        logic [DELAY_W-1:0] delay_tab[TASKS];
        logic [1:0]         mode_tab[TASKS];
        bit                 pend_tab[TASKS];
        logic [TICK_W-1:0]  last_tick;
        sched_word_t        sched_out_q[$];
        int                 errors;

        function new();
            for (int i = 0; i < TASKS; i++)
            begin
                delay_tab[i] = '0;
                mode_tab[i]  = MODE_OFF;
                pend_tab[i]  = 1'b0;
            end
            last_tick = '0;
            errors    = 0;
        endfunction

        function void note_request(logic [1:0] req, logic [TID_W-1:0] id, logic [1:0] mode,
                                   logic [DELAY_W-1:0] first, logic [TICK_W-1:0] now,
                                   logic [TICK_W-1:0] ff, logic [TICK_W-1:0] nd);
            logic [TICK_W-1:0]  elapsed;
            logic [TID_W-1:0]   runs[$];
            logic [DELAY_W-1:0] min_w;
            logic               any_f;
            sched_word_t        w;
            case (req)
                REQ_SET:
                begin
                    if (mode != MODE_RSVD)
                    begin
                        if (mode == MODE_ARMED)
                            delay_tab[id] = first;
                        mode_tab[id] = mode;
                        pend_tab[id] = 1'b0;
                    end
                end
                REQ_ADV:
                begin
                    elapsed   = now - last_tick + ff;
                    last_tick = now;
                    for (int i = 0; i < TASKS; i++)
                    begin
                        if (mode_tab[i] != MODE_OFF && !pend_tab[i])
                        begin
                            if (mode_tab[i] == MODE_FORCED || {1'b0, delay_tab[i]} <= elapsed)
                            begin
                                pend_tab[i] = 1'b1;
                                runs.push_back(i[TID_W-1:0]);
                            end
                            else
                                // delay > elapsed here, so the low bits are exact
                                delay_tab[i] = delay_tab[i] - elapsed[DELAY_W-1:0];
                        end
                    end
                end
                REQ_DONE:
                begin
                    if (!nd[TICK_W-1])
                    begin
                        delay_tab[id] = nd[DELAY_W-1:0];
                        mode_tab[id]  = MODE_ARMED;
                    end
                    else
                        mode_tab[id] = MODE_OFF;
                    pend_tab[id] = 1'b0;
                end
                default: ;
            endcase

            min_w = NO_WAIT;
            any_f = 1'b0;
            for (int i = 0; i < TASKS; i++)
            begin
                if (mode_tab[i] == MODE_FORCED)
                    any_f = 1'b1;
                if (mode_tab[i] != MODE_OFF && !pend_tab[i] && delay_tab[i] < min_w)
                    min_w = delay_tab[i];
            end

            foreach (runs[k])
            begin
                w = '{kind: KIND_RUN, id: runs[k], min_wait: min_w, forced: any_f, last: 1'b0};
                sched_out_q.push_back(w);
            end
            w = '{kind: KIND_STATUS, id: '0, min_wait: min_w, forced: any_f, last: 1'b1};
            sched_out_q.push_back(w);
        endfunction

        function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
            if (exp_v != got_v)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(sched_word_t got);
            sched_word_t exp_w;
            if (sched_out_q.size() == 0)
            begin
                $error("unexpected output word: kind %0d id %0d", got.kind, got.id);
                errors++;
                return;
            end
            exp_w = sched_out_q.pop_front();
            compare_field("result_kind", exp_w.kind, got.kind);
            compare_field("run_task_id", exp_w.id, got.id);
            compare_field("shortest_wait", exp_w.min_wait, got.min_wait);
            compare_field("any_forced", exp_w.forced, got.forced);
            compare_field("last_result", exp_w.last, got.last);
        endfunction
    endclass

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    sched_tracker sb = new();
    int           burst_left = 0;

    task_due_time_scheduler #(
        .TASKS(TASKS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver stall pattern: switches between four ready styles at random
    int       rx_mode = 0;
    int       rx_left = 0;
    logic [4:0] rx_cnt = '0;

    always @(posedge clk)
    begin
        rx_cnt <= rx_cnt + 5'd1;
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 400);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (rx_cnt >= 5'd12);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result('{kind: m_axis_tuser, id: m_axis_tdata[3:0],
                              min_wait: m_axis_tdata[34:4], forced: m_axis_tdata[35],
                              last: m_axis_tlast});
    end

    // one request word; sender runs in bursts with idle gaps between them
    task automatic send_request(input logic [1:0] req, input logic [TID_W-1:0] id,
                                input logic [1:0] mode, input logic [DELAY_W-1:0] first,
                                input logic [TICK_W-1:0] now, input logic [TICK_W-1:0] ff,
                                input logic [TICK_W-1:0] nd);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {3'b000, nd, ff, now, first, mode, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(req, id, mode, first, now, ff, nd);
        burst_left--;
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [1:0]         req;
        logic [TID_W-1:0]   id;
        logic [1:0]         mode;
        logic [DELAY_W-1:0] first;
        logic [TICK_W-1:0]  now;
        logic [TICK_W-1:0]  ff;
        logic [TICK_W-1:0]  nd;
        logic [TICK_W-1:0]  cur_now;
        int                 pick;
        int                 cand[$];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table right after reset
        send_request(REQ_ADV, 4'd0, MODE_OFF, '0, 32'd0, 32'd0, 32'd0);

        // fill every task: odd ones forced, even ones armed incl. zero and max delay
        for (int i = 0; i < TASKS; i++)
        begin
            if (i % 2 == 1)
                send_request(REQ_SET, i[3:0], MODE_FORCED, 31'($urandom), $urandom,
                             $urandom, $urandom);
            else
            begin
                first = (i == 0) ? 31'd0 : (i == 2) ? NO_WAIT : 31'($urandom);
                send_request(REQ_SET, i[3:0], MODE_ARMED, first, $urandom, $urandom, $urandom);
            end
        end
        // reserved mode leaves task 5 alone
        send_request(REQ_SET, 4'd5, MODE_RSVD, '0, '0, '0, '0);
        // max fast-forward: every task runs, sixteen run words plus status
        send_request(REQ_ADV, 4'd0, MODE_OFF, '0, 32'd0, 32'hffff_ffff, '0);
        // everything pending: nothing runs, nothing is reduced
        send_request(REQ_ADV, 4'd0, MODE_OFF, '0, 32'h10, 32'd0, '0);
        send_request(REQ_DONE, 4'd1, MODE_OFF, '0, '0, '0, 32'h8000_0000);
        send_request(REQ_DONE, 4'd0, MODE_OFF, '0, '0, '0, 32'd0);
        send_request(REQ_DONE, 4'd2, MODE_OFF, '0, '0, '0, 32'h7fff_ffff);
        // a set on a pending task drops its pending mark
        send_request(REQ_SET, 4'd3, MODE_ARMED, 31'd50, '0, '0, '0);
        send_request(REQ_RSVD, 4'($urandom), 2'($urandom), 31'($urandom), $urandom, $urandom,
                     $urandom);
        // tick goes backwards: elapsed wraps to a huge value
        send_request(REQ_ADV, 4'd0, MODE_OFF, '0, 32'd5, 32'd0, '0);
        // completion for a task that is off and not pending
        send_request(REQ_DONE, 4'd1, MODE_OFF, '0, '0, '0, 32'd25);
        send_request(REQ_DONE, 4'd15, MODE_OFF, '0, '0, '0, 32'hffff_ffff);

        cur_now = 32'd5;
        for (int n = 0; n < 500; n++)
        begin
            // unused fields carry random bits
            id    = 4'($urandom_range(0, TASKS - 1));
            mode  = 2'($urandom);
            first = 31'($urandom);
            now   = $urandom;
            ff    = $urandom;
            nd    = $urandom;
            pick  = $urandom_range(0, 99);
            if (pick < 30)
            begin
                req  = REQ_SET;
                pick = $urandom_range(0, 9);
                mode = (pick < 6) ? MODE_ARMED : (pick < 8) ? MODE_FORCED
                     : (pick < 9) ? MODE_OFF : MODE_RSVD;
                if ($urandom_range(0, 4) != 0)
                    first = 31'($urandom_range(0, 600));
            end
            else if (pick < 60)
            begin
                req = REQ_ADV;
                if ($urandom_range(0, 9) != 0)
                    now = cur_now + $urandom_range(0, 300);
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    ff = 32'd0;
                else if (pick < 9)
                    ff = $urandom_range(0, 200);
                cur_now = now;
            end
            else if (pick < 95)
            begin
                req = REQ_DONE;
                cand.delete();
                for (int t = 0; t < TASKS; t++)
                    if (sb.pend_tab[t])
                        cand.push_back(t);
                if (cand.size() != 0)
                    id = 4'(cand[$urandom_range(0, cand.size() - 1)]);
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    nd = $urandom_range(0, 600);
                else if (pick < 17)
                    nd = $urandom | 32'h8000_0000;
            end
            else
                req = REQ_RSVD;
            send_request(req, id, mode, first, now, ff, nd);
        end
        if (burst_left != 0)
            s_axis_tvalid <= 1'b0;

        while (sb.sched_out_q.size() != 0)
            @(posedge clk);
        repeat (2 * (TASKS + 3) + 8) @(posedge clk);

        if (sb.errors == 0 && sb.sched_out_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tdts_pkg.sv
rtl/tdts_cell.sv
rtl/task_due_time_scheduler.sv
tb/tb_task_due_time_scheduler.sv
